FILE: rtl/kcfc_pkg.sv
`default_nettype none

package kcfc_pkg;

   // frame layout and default sizes
   localparam int MAX_FRAME_DEF      = 250;
   localparam int HEADER_LEN         = 7;
   localparam int MAX_KEY_BYTES_DEF  = 16;
   localparam int KEY_BYTES_PER_STEP = 4;

   localparam logic [7:0] CRC_POLY = 8'h07;

   // configuration register indexes
   localparam int         CSR_INDEX_W     = 3;
   localparam logic [2:0] CSR_EXP_MAGIC   = 3'd0;
   localparam logic [2:0] CSR_EXP_VERSION = 3'd1;
   localparam logic [2:0] CSR_KEY_LOW     = 3'd2;
   localparam logic [2:0] CSR_KEY_HIGH    = 3'd3;
   localparam logic [2:0] CSR_KEY_LENGTH  = 3'd4;

   // header byte positions
   localparam logic [7:0] POS_MAGIC_LO = 8'd0;
   localparam logic [7:0] POS_MAGIC_HI = 8'd1;
   localparam logic [7:0] POS_VERSION  = 8'd2;
   localparam logic [7:0] POS_TYPE     = 8'd3;
   localparam logic [7:0] POS_SEQ_LO   = 8'd4;
   localparam logic [7:0] POS_SEQ_HI   = 8'd5;
   localparam logic [7:0] POS_CRC      = 8'd6;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_TOO_SHORT = 3'd1,
      STATUS_TOO_LONG  = 3'd2,
      STATUS_BAD_MAGIC = 3'd3,
      STATUS_VERSION   = 3'd4,
      STATUS_BAD_CRC   = 3'd5
   } kcfc_status_type;

   // key fold as a linear map: result = sum of col[b] for set crc bits, xor key_crc
   typedef struct packed {
      logic [7:0]      key_crc;
      logic [7:0][7:0] col;
   } kcfc_fold_type;

   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   function automatic logic [7:0] fold_apply(input kcfc_fold_type f, input logic [7:0] crc);
      logic [7:0] r;
      r = f.key_crc;
      for (int b = 0; b < 8; b++) begin
         if (crc[b]) begin
            r = r ^ f.col[b];
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/kcfc_if.sv
`default_nettype none

interface kcfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       last_byte;
   modport source (output valid, byte_in, last_byte, input ready);
   modport sink   (input valid, byte_in, last_byte, output ready);
endinterface

interface kcfc_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_out;
   logic        is_payload;
   logic        end_of_frame;
   logic [2:0]  status;
   logic [7:0]  frame_type;
   logic [15:0] sequence_res;
   logic [7:0]  payload_length;
   logic [7:0]  seen_version;
   modport source (output valid, data_out, is_payload, end_of_frame, status, frame_type,
                   sequence_res, payload_length, seen_version, input ready);
   modport sink   (input valid, data_out, is_payload, end_of_frame, status, frame_type,
                   sequence_res, payload_length, seen_version, output ready);
endinterface

interface kcfc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

FILE: rtl/kcfc_key_fold.sv
`default_nettype none

module kcfc_key_fold #(
   parameter int MAX_KEY_BYTES = kcfc_pkg::MAX_KEY_BYTES_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    restart,
   input  wire logic [63:0]             key_low,
   input  wire logic [63:0]             key_high,
   input  wire logic [4:0]              key_length,
   output kcfc_pkg::kcfc_fold_type      fold
);
   import kcfc_pkg::*;

   localparam int StepsLp = (MAX_KEY_BYTES + KEY_BYTES_PER_STEP - 1) / KEY_BYTES_PER_STEP;
   localparam int StepW   = (StepsLp > 1) ? $clog2(StepsLp) : 1;

   logic                run_ff, run_in;
   logic [StepW-1:0]    step_ff, step_in;
   kcfc_fold_type       fold_ff, fold_in;
   logic [127:0]        key_all;
   logic [4:0]          n_lim;

   assign key_all = {key_high, key_low};
   assign n_lim   = (key_length > 5'(MAX_KEY_BYTES)) ? 5'(MAX_KEY_BYTES) : key_length;
   assign fold    = fold_ff;

   // four key bytes per cycle, zero-byte advance of each basis column alongside
   always_comb begin
      logic [4:0]    j;
      kcfc_fold_type f;
      f = fold_ff;
      for (int k = 0; k < KEY_BYTES_PER_STEP; k++) begin
         j = 5'(KEY_BYTES_PER_STEP * int'(step_ff) + k);
         if (j < n_lim) begin
            f.key_crc = crc8_byte(f.key_crc, key_all[{j[3:0], 3'b000} +: 8]);
            for (int b = 0; b < 8; b++) begin
               f.col[b] = crc8_byte(f.col[b], 8'h00);
            end
         end
      end
      if (restart) begin
         fold_in.key_crc = 8'h00;
         for (int b = 0; b < 8; b++) begin
            fold_in.col[b] = 8'(1) << b;
         end
      end else if (run_ff) begin
         fold_in = f;
      end else begin
         fold_in = fold_ff;
      end
   end

   always_comb begin
      if (restart) begin
         run_in  = 1'b1;
         step_in = '0;
      end else if (run_ff) begin
         run_in  = (step_ff != StepW'(StepsLp - 1));
         step_in = step_ff + StepW'(1);
      end else begin
         run_in  = 1'b0;
         step_in = step_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff          <= 1'b0;
         step_ff         <= '0;
         fold_ff.key_crc <= 8'h00;
         for (int b = 0; b < 8; b++) begin
            fold_ff.col[b] <= 8'(1) << b;
         end
      end else begin
         run_ff  <= run_in;
         step_ff <= step_in;
         fold_ff <= fold_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/keyed_crc8_frame_checker_unit.sv
// keyed crc-8 frame checker
// req_ch: one received byte per request, last_byte marks the end of a frame.
// rsp_ch: one result per request: the byte echoed with a payload mark, and on
//   the last byte the verdict, header type, sequence, payload length and version.
// csr_ch: register writes (magic, version, key low, key high, key length), always
//   ready; write only while no frame is in progress and no result is pending.
// flow: a request accepted into the input register passes the single crc step into
//   the result register, visible until taken; one request per cycle sustained while
//   rsp_ch.ready stays high.
// after a csr write up to MAX_KEY_BYTES key bytes are pre-folded four per cycle.
// reset: control and configuration registers return to zero, frame state is cleared,
//   both channels empty; byte and result payload registers are not reset.
// stall: while rsp_ch.ready is low the result register holds and one more request
//   may wait in the input register; req_ch.ready drops only when both are full.
`default_nettype none

module keyed_crc8_frame_checker_unit #(
   parameter int MAX_FRAME     = kcfc_pkg::MAX_FRAME_DEF,
   parameter int MAX_KEY_BYTES = kcfc_pkg::MAX_KEY_BYTES_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   kcfc_req_if.sink   req_ch,
   kcfc_rsp_if.source rsp_ch,
   kcfc_csr_if.sink   csr_ch
);
   import kcfc_pkg::*;

   localparam logic [7:0] MaxFrameLp  = 8'(MAX_FRAME);
   localparam logic [7:0] LongPlenLp  = 8'(MAX_FRAME - HEADER_LEN);
   localparam logic [8:0] HeaderLenLp = 9'(HEADER_LEN);

   // configuration registers
   logic [15:0] exp_magic_ff, exp_magic_in;
   logic [7:0]  exp_version_ff, exp_version_in;
   logic [63:0] key_low_ff, key_low_in;
   logic [63:0] key_high_ff, key_high_in;
   logic [4:0]  key_length_ff, key_length_in;
   logic        csr_write;
   kcfc_fold_type fold;

   // input register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff, s1_byte_in;
   logic       s1_last_ff, s1_last_in;

   // frame state
   logic [7:0]  crc_acc_ff, crc_acc_in;
   logic [7:0]  byte_count_ff, byte_count_in;
   logic [15:0] magic_hold_ff, magic_hold_in;
   logic [7:0]  version_hold_ff, version_hold_in;
   logic [7:0]  type_hold_ff, type_hold_in;
   logic [15:0] seq_hold_ff, seq_hold_in;
   logic [7:0]  rcv_crc_ff, rcv_crc_in;
   logic        overflow_ff, overflow_in;

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      data_ff, data_in;
   logic            payload_ff, payload_in;
   logic            eof_ff, eof_in;
   kcfc_status_type status_ff, status_in;
   logic [7:0]      type_ff, type_in;
   logic [15:0]     seq_ff, seq_in;
   logic [7:0]      plen_ff, plen_in;
   logic [7:0]      version_ff, version_in;

   // handshakes
   logic out_free, advance, accept;

   // per-byte working values
   logic [7:0]  pos;
   logic [8:0]  len;
   logic        ovf_now;
   logic [7:0]  crc_next;
   logic [15:0] magic_next, seq_next;
   logic [7:0]  version_next, type_next, rcv_next;

   // ---------------------------------------------------------------- csr port
   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid;

   always_comb begin
      exp_magic_in   = exp_magic_ff;
      exp_version_in = exp_version_ff;
      key_low_in     = key_low_ff;
      key_high_in    = key_high_ff;
      key_length_in  = key_length_ff;
      if (csr_write) begin
         case (csr_ch.index)
            CSR_EXP_MAGIC:   exp_magic_in   = csr_ch.wdata[15:0];
            CSR_EXP_VERSION: exp_version_in = csr_ch.wdata[7:0];
            CSR_KEY_LOW:     key_low_in     = csr_ch.wdata;
            CSR_KEY_HIGH:    key_high_in    = csr_ch.wdata;
            CSR_KEY_LENGTH:  key_length_in  = csr_ch.wdata[4:0];
            default:         ; // unknown index, write dropped
         endcase
      end
   end

   // key contribution recomputed after every csr write
   kcfc_key_fold #(
      .MAX_KEY_BYTES (MAX_KEY_BYTES)
   ) u_key_fold (
      .clock      (clock),
      .reset      (reset),
      .restart    (csr_write),
      .key_low    (key_low_in),
      .key_high   (key_high_in),
      .key_length (key_length_in),
      .fold       (fold)
   );

   // ---------------------------------------------------------------- flow control
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign advance      = s1_valid_ff && out_free;
   assign req_ch.ready = !s1_valid_ff || out_free;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      s1_byte_in  = accept ? req_ch.byte_in : s1_byte_ff;
      s1_last_in  = accept ? req_ch.last_byte : s1_last_ff;
      rsp_valid_in = advance ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
   end

   // ---------------------------------------------------------------- frame update
   assign pos     = byte_count_ff;
   assign len     = {1'b0, pos} + 9'd1;
   assign ovf_now = overflow_ff || (pos >= MaxFrameLp);

   always_comb begin
      magic_next   = magic_hold_ff;
      version_next = version_hold_ff;
      type_next    = type_hold_ff;
      seq_next     = seq_hold_ff;
      rcv_next     = rcv_crc_ff;
      case (pos)
         POS_MAGIC_LO: magic_next[7:0]  = s1_byte_ff;
         POS_MAGIC_HI: magic_next[15:8] = s1_byte_ff;
         POS_VERSION:  version_next     = s1_byte_ff;
         POS_TYPE:     type_next        = s1_byte_ff;
         POS_SEQ_LO:   seq_next[7:0]    = s1_byte_ff;
         POS_SEQ_HI:   seq_next[15:8]   = s1_byte_ff;
         POS_CRC:      rcv_next         = s1_byte_ff;
         default:      ; // payload byte, header untouched
      endcase
      // the crc byte itself stays out of the running crc
      crc_next = (pos != POS_CRC) ? crc8_byte(crc_acc_ff, s1_byte_ff) : crc_acc_ff;
   end

   always_comb begin
      crc_acc_in      = crc_acc_ff;
      byte_count_in   = byte_count_ff;
      magic_hold_in   = magic_hold_ff;
      version_hold_in = version_hold_ff;
      type_hold_in    = type_hold_ff;
      seq_hold_in     = seq_hold_ff;
      rcv_crc_in      = rcv_crc_ff;
      overflow_in     = overflow_ff;
      if (advance) begin
         if (s1_last_ff) begin
            // end of frame, start the next one clean
            crc_acc_in      = 8'h00;
            byte_count_in   = 8'h00;
            magic_hold_in   = 16'h0000;
            version_hold_in = 8'h00;
            type_hold_in    = 8'h00;
            seq_hold_in     = 16'h0000;
            rcv_crc_in      = 8'h00;
            overflow_in     = 1'b0;
         end else begin
            crc_acc_in      = crc_next;
            byte_count_in   = (byte_count_ff != 8'hFF) ? byte_count_ff + 8'd1 : byte_count_ff;
            magic_hold_in   = magic_next;
            version_hold_in = version_next;
            type_hold_in    = type_next;
            seq_hold_in     = seq_next;
            rcv_crc_in      = rcv_next;
            overflow_in     = ovf_now;
         end
      end
   end

   // ---------------------------------------------------------------- verdict
   always_comb begin
      data_in    = data_ff;
      payload_in = payload_ff;
      eof_in     = eof_ff;
      status_in  = status_ff;
      type_in    = type_ff;
      seq_in     = seq_ff;
      plen_in    = plen_ff;
      version_in = version_ff;
      if (advance) begin
         data_in    = s1_byte_ff;
         payload_in = ({1'b0, pos} >= HeaderLenLp);
         eof_in     = s1_last_ff;
         status_in  = STATUS_OK;
         type_in    = 8'h00;
         seq_in     = 16'h0000;
         plen_in    = 8'h00;
         version_in = 8'h00;
         if (s1_last_ff) begin
            type_in    = type_next;
            seq_in     = seq_next;
            version_in = version_next;
            if (len < HeaderLenLp) begin
               status_in = STATUS_TOO_SHORT;
            end else if (ovf_now) begin
               status_in = STATUS_TOO_LONG;
               plen_in   = LongPlenLp;
            end else begin
               plen_in = 8'(len - HeaderLenLp);
               // version mismatch takes precedence over the crc check
               if (magic_next != exp_magic_ff) begin
                  status_in = STATUS_BAD_MAGIC;
               end else if (version_next != exp_version_ff) begin
                  status_in = STATUS_VERSION;
               end else if (fold_apply(fold, crc_next) != rcv_next) begin
                  status_in = STATUS_BAD_CRC;
               end else begin
                  status_in = STATUS_OK;
               end
            end
         end
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.data_out       = data_ff;
   assign rsp_ch.is_payload     = payload_ff;
   assign rsp_ch.end_of_frame   = eof_ff;
   assign rsp_ch.status         = status_ff;
   assign rsp_ch.frame_type     = type_ff;
   assign rsp_ch.sequence_res   = seq_ff;
   assign rsp_ch.payload_length = plen_ff;
   assign rsp_ch.seen_version   = version_ff;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_magic_ff    <= 16'h0000;
         exp_version_ff  <= 8'h00;
         key_low_ff      <= 64'h0;
         key_high_ff     <= 64'h0;
         key_length_ff   <= 5'd0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         crc_acc_ff      <= 8'h00;
         byte_count_ff   <= 8'h00;
         magic_hold_ff   <= 16'h0000;
         version_hold_ff <= 8'h00;
         type_hold_ff    <= 8'h00;
         seq_hold_ff     <= 16'h0000;
         rcv_crc_ff      <= 8'h00;
         overflow_ff     <= 1'b0;
      end else begin
         exp_magic_ff    <= exp_magic_in;
         exp_version_ff  <= exp_version_in;
         key_low_ff      <= key_low_in;
         key_high_ff     <= key_high_in;
         key_length_ff   <= key_length_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         crc_acc_ff      <= crc_acc_in;
         byte_count_ff   <= byte_count_in;
         magic_hold_ff   <= magic_hold_in;
         version_hold_ff <= version_hold_in;
         type_hold_ff    <= type_hold_in;
         seq_hold_ff     <= seq_hold_in;
         rcv_crc_ff      <= rcv_crc_in;
         overflow_ff     <= overflow_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      s1_byte_ff <= s1_byte_in;
      s1_last_ff <= s1_last_in;
      data_ff    <= data_in;
      payload_ff <= payload_in;
      eof_ff     <= eof_in;
      status_ff  <= status_in;
      type_ff    <= type_in;
      seq_ff     <= seq_in;
      plen_ff    <= plen_in;
      version_ff <= version_in;
   end

endmodule

`default_nettype wire
